FILE: design/shbi_pkg.sv
// shared types and constants for the sorted hash bucket indexer
// no dependencies; imported by every module of the block
package shbi_pkg;

  // bucket index width limits and run-length class boundary
  localparam logic [4:0]  MIN_BUCKET_BITS = 5'd8;
  localparam logic [4:0]  RESET_BUCKET_BITS = 5'd16;
  localparam logic [6:0]  HASH_BITS = 7'd64;
  localparam logic [31:0] MID_RUN_LIMIT = 32'd100;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // input word: one sorted hash or the end-of-set marker
  typedef struct packed {
    logic [63:0] hash_value;
    logic        end_of_set;
  } in_word_t;

  // result word: fill command, closed run and set summary
  typedef struct packed {
    logic        fill_valid;
    logic [31:0] fill_first;
    logic [31:0] fill_last;
    logic [31:0] fill_position;
    logic        run_closed;
    logic [31:0] run_length;
    logic        is_summary;
    logic [31:0] distinct_count;
    logic [31:0] single_count;
    logic [31:0] mid_count;
    logic [31:0] high_count;
  } out_word_t;

endpackage

FILE: design/shbi_in_stage.sv
// input register of the sorted hash bucket indexer
// depends on shbi_pkg for the input word type
module shbi_in_stage import shbi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  input  logic     advance,
  output logic     item_valid,
  output in_word_t item_data
);

  logic     item_valid_r;
  logic     item_valid_nxt;
  in_word_t item_data_r;
  logic     accept;

  // hold while the held word cannot move on
  assign in_stall = item_valid_r & ~advance;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (accept) begin
      item_valid_nxt = 1'b1;
    end else if (advance) begin
      item_valid_nxt = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item_data_r <= in_data;
    end
  end

  assign item_valid = item_valid_r;
  assign item_data  = item_data_r;

endmodule

FILE: design/shbi_step.sv
// set state and single-pass step logic of the sorted hash bucket indexer
// depends on shbi_pkg for word types and constants
module shbi_step import shbi_pkg::*; #(
  parameter int POSITION_WIDTH  = 32,
  parameter int MAX_BUCKET_BITS = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [4:0] bucket_bits,
  input  logic       item_valid,
  input  in_word_t   item_data,
  input  logic       advance,
  output logic       res_valid,
  output out_word_t  res_data
);

  localparam int                  NBW     = MAX_BUCKET_BITS + 1;
  localparam logic [4:0]          MAX_B   = 5'(MAX_BUCKET_BITS);
  localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == COUNT_MAX) ? v : v + 32'd1;
  endfunction

  // set state
  logic                      seen_any_r, seen_any_nxt;
  logic [POSITION_WIDTH-1:0] item_position_r, item_position_nxt;
  logic [63:0]               previous_hash_r, previous_hash_nxt;
  logic [31:0]               current_run_r, current_run_nxt;
  logic [NBW-1:0]            next_bucket_r, next_bucket_nxt;
  logic [31:0]               distinct_total_r, distinct_total_nxt;
  logic [31:0]               single_total_r, single_total_nxt;
  logic [31:0]               mid_total_r, mid_total_nxt;
  logic [31:0]               high_total_r, high_total_nxt;

  logic [4:0]                eff_bits;
  logic [6:0]                shift_amt;
  logic [63:0]               shifted;
  logic [31:0]               bucket;
  logic [31:0]               table_end;
  logic [31:0]               fill_first;
  logic [31:0]               fill_last;
  logic [31:0]               fill_last_inc;
  logic                      fill_ok;
  logic                      is_repeat;
  logic [POSITION_WIDTH-1:0] pos_inc;
  logic [31:0]               single_tal, mid_tal, high_tal;
  logic                      fire;

  assign fire = item_valid & advance;

  always_comb begin
    // clamp the bucket width into the supported range
    eff_bits = bucket_bits;
    if (eff_bits < MIN_BUCKET_BITS) begin
      eff_bits = MIN_BUCKET_BITS;
    end
    if (eff_bits > MAX_B) begin
      eff_bits = MAX_B;
    end

    // bucket index from the top bits of the hash
    shift_amt = HASH_BITS - {2'b00, eff_bits};
    shifted   = item_data.hash_value >> shift_amt;
    bucket    = shifted[31:0];
    table_end = 32'd1 << eff_bits;

    is_repeat = seen_any_r && (item_data.hash_value == previous_hash_r);
    pos_inc   = (item_position_r == POS_MAX) ? item_position_r
                                             : item_position_r + 1'b1;

    // fill range from the first unwritten entry
    fill_first    = 32'(next_bucket_r);
    fill_last     = item_data.end_of_set ? table_end : bucket;
    fill_last_inc = fill_last + 32'd1;
    fill_ok       = fill_last >= fill_first;

    // class the run that closes now
    single_tal = single_total_r;
    mid_tal    = mid_total_r;
    high_tal   = high_total_r;
    if (seen_any_r) begin
      if (current_run_r == 32'd1) begin
        single_tal = sat_inc(single_total_r);
      end else if (current_run_r > MID_RUN_LIMIT) begin
        high_tal = sat_inc(high_total_r);
      end else begin
        mid_tal = sat_inc(mid_total_r);
      end
    end

    seen_any_nxt       = seen_any_r;
    item_position_nxt  = item_position_r;
    previous_hash_nxt  = previous_hash_r;
    current_run_nxt    = current_run_r;
    next_bucket_nxt    = next_bucket_r;
    distinct_total_nxt = distinct_total_r;
    single_total_nxt   = single_total_r;
    mid_total_nxt      = mid_total_r;
    high_total_nxt     = high_total_r;
    res_valid          = 1'b0;
    res_data           = '0;

    if (item_data.end_of_set) begin
      // close the set, final fill and summary, then start afresh
      res_valid = 1'b1;
      if (seen_any_r) begin
        res_data.run_closed = 1'b1;
        res_data.run_length = current_run_r;
      end
      if (fill_ok) begin
        res_data.fill_valid    = 1'b1;
        res_data.fill_first    = fill_first;
        res_data.fill_last     = fill_last;
        res_data.fill_position = 32'(item_position_r);
      end
      res_data.is_summary     = 1'b1;
      res_data.distinct_count = distinct_total_r;
      res_data.single_count   = single_tal;
      res_data.mid_count      = mid_tal;
      res_data.high_count     = high_tal;
      seen_any_nxt       = 1'b0;
      item_position_nxt  = '0;
      previous_hash_nxt  = '0;
      current_run_nxt    = '0;
      next_bucket_nxt    = '0;
      distinct_total_nxt = '0;
      single_total_nxt   = '0;
      mid_total_nxt      = '0;
      high_total_nxt     = '0;
    end else if (is_repeat) begin
      // same hash again: the run grows
      current_run_nxt   = sat_inc(current_run_r);
      item_position_nxt = pos_inc;
    end else begin
      // new distinct hash
      res_valid = 1'b1;
      if (seen_any_r) begin
        res_data.run_closed = 1'b1;
        res_data.run_length = current_run_r;
      end
      single_total_nxt   = single_tal;
      mid_total_nxt      = mid_tal;
      high_total_nxt     = high_tal;
      distinct_total_nxt = sat_inc(distinct_total_r);
      if (fill_ok) begin
        res_data.fill_valid    = 1'b1;
        res_data.fill_first    = fill_first;
        res_data.fill_last     = fill_last;
        res_data.fill_position = 32'(item_position_r);
        next_bucket_nxt        = fill_last_inc[NBW-1:0];
      end
      seen_any_nxt      = 1'b1;
      previous_hash_nxt = item_data.hash_value;
      current_run_nxt   = 32'd1;
      item_position_nxt = pos_inc;
    end

    if (!item_valid) begin
      res_valid = 1'b0;
    end
  end

  // state update when the held word is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_any_r       <= 1'b0;
      item_position_r  <= '0;
      previous_hash_r  <= '0;
      current_run_r    <= '0;
      next_bucket_r    <= '0;
      distinct_total_r <= '0;
      single_total_r   <= '0;
      mid_total_r      <= '0;
      high_total_r     <= '0;
    end else if (fire) begin
      seen_any_r       <= seen_any_nxt;
      item_position_r  <= item_position_nxt;
      previous_hash_r  <= previous_hash_nxt;
      current_run_r    <= current_run_nxt;
      next_bucket_r    <= next_bucket_nxt;
      distinct_total_r <= distinct_total_nxt;
      single_total_r   <= single_total_nxt;
      mid_total_r      <= mid_total_nxt;
      high_total_r     <= high_total_nxt;
    end
  end

endmodule

FILE: design/shbi_out_stage.sv
// result register of the sorted hash bucket indexer
// depends on shbi_pkg for the result word type
module shbi_out_stage import shbi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_word_t load_data,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t out_data_r;

  // free when empty or being taken this cycle
  assign ready = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= load_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/sorted_hash_bucket_indexer_core.sv
// top level of the sorted hash bucket indexer
// depends on shbi_pkg, shbi_in_stage, shbi_step and shbi_out_stage
//
//   channel | direction | handshake        | word
//   --------+-----------+------------------+------------------------------
//   in_     | in        | valid / stall    | in_word_t (hash or end marker)
//   out_    | out       | valid / stall    | out_word_t (fill, run, summary)
//   cfg_    | in        | valid / ready    | bucket_bits, 5 bits
//
// one word per cycle sustained while out_stall is low; a result passes through
// the input register, step logic and result register
// words that only lengthen a run give no result
// reset is synchronous, active low; cfg_ready is always high
// a stalled result holds the pipe; while both registers hold a word, in_stall follows out_stall in the same cycle
module sorted_hash_bucket_indexer_core import shbi_pkg::*; #(
  parameter int POSITION_WIDTH  = 32,
  parameter int MAX_BUCKET_BITS = 31
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  logic       cfg_write;
  logic [4:0] bucket_bits_r;
  logic       item_valid;
  in_word_t   item_data;
  logic       advance;
  logic       res_valid;
  out_word_t  res_data;

  // configuration register
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_bits_r <= RESET_BUCKET_BITS;
    end else if (cfg_write) begin
      bucket_bits_r <= cfg_data;
    end
  end

  shbi_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item_data  (item_data)
  );

  shbi_step #(
    .POSITION_WIDTH  (POSITION_WIDTH),
    .MAX_BUCKET_BITS (MAX_BUCKET_BITS)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .bucket_bits (bucket_bits_r),
    .item_valid  (item_valid),
    .item_data   (item_data),
    .advance     (advance),
    .res_valid   (res_valid),
    .res_data    (res_data)
  );

  // result register takes a word whenever the step hands one over
  shbi_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid & advance),
    .load_data (res_data),
    .ready     (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
